// ===== design/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg
// Shared widths, register indexes, reset values and types for the averaged
// sensor to position block.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int SAMPLE_W = 20;
    localparam int DEPTH_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = $clog2(SAMPLE_W + 1);

    localparam int DEFAULT_WINDOW_DEPTH = 32;
    localparam int DEFAULT_SCREEN_WIDTH = 640;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd2;

    localparam logic [SAMPLE_W-1:0] LEFT_RESET  = 20'd0;
    localparam logic [SAMPLE_W-1:0] RIGHT_RESET = 20'd201274;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET = 6'd20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_bound;
        logic [SAMPLE_W-1:0] right_bound;
        logic [DEPTH_W-1:0]  avg_depth;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] rem_init;
        logic [SAMPLE_W-1:0] quot_init;
        logic [SAMPLE_W-1:0] divisor;
        logic [STEP_W-1:0]   steps;
    } div_req_t;

endpackage

// ===== design/asp_front.sv =====
// ----------------------------------------------------------------------------
// asp_front
// Input queue that takes sensor samples and holds them until the back end
// is free to process the next one.
// ----------------------------------------------------------------------------
module asp_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [asp_pkg::SAMPLE_W-1:0] sample,
    input  logic                         q_pop,
    output logic                         q_empty,
    output logic [asp_pkg::SAMPLE_W-1:0] q_data
);

    localparam int PTR_W = $clog2(asp_pkg::QUEUE_DEPTH);

    logic [asp_pkg::SAMPLE_W-1:0] slot_reg [asp_pkg::QUEUE_DEPTH];
    logic [PTR_W:0]               wr_ptr_reg;
    logic [PTR_W:0]               wr_ptr_next;
    logic [PTR_W:0]               rd_ptr_reg;
    logic [PTR_W:0]               rd_ptr_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_empty = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W])
                  && (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;
    assign q_data  = slot_reg[rd_ptr_reg[PTR_W-1:0]];

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg[PTR_W-1:0]] <= sample;
        end
    end

endmodule

// ===== design/asp_div.sv =====
// ----------------------------------------------------------------------------
// asp_div
// Restoring divider that produces one quotient bit per cycle. The caller
// loads the upper part of the dividend as the starting remainder, which
// must be below the divisor.
// ----------------------------------------------------------------------------
module asp_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  asp_pkg::div_req_t            div_req,
    output logic                         div_busy,
    output logic [asp_pkg::SAMPLE_W-1:0] div_quot
);

    localparam int W = asp_pkg::SAMPLE_W;

    logic [W-1:0]                    rem_reg;
    logic [W-1:0]                    rem_next;
    logic [W-1:0]                    quot_reg;
    logic [W-1:0]                    quot_next;
    logic [W-1:0]                    divisor_reg;
    logic [asp_pkg::STEP_W-1:0]      steps_reg;
    logic                            busy_reg;
    logic [W:0]                      trial;
    logic                            fits;

    assign trial = {rem_reg, quot_reg[W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        rem_next  = fits ? W'(trial - {1'b0, divisor_reg}) : trial[W-1:0];
        quot_next = {quot_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else if (div_req.start)
        begin
            busy_reg  <= 1'b1;
            steps_reg <= div_req.steps;
        end
        else if (busy_reg)
        begin
            steps_reg <= steps_reg - 1'b1;
            if (steps_reg == asp_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg     <= div_req.rem_init;
            quot_reg    <= div_req.quot_init;
            divisor_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign div_busy = busy_reg;
    assign div_quot = quot_reg;

endmodule

// ===== design/asp_back.sv =====
// ----------------------------------------------------------------------------
// asp_back
// Sequencer that shifts each sample into the window memory, sums the newest
// samples, divides by their count and maps the average onto a column.
// ----------------------------------------------------------------------------
module asp_back
#(
    parameter int WINDOW_DEPTH = asp_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SCREEN_WIDTH = asp_pkg::DEFAULT_SCREEN_WIDTH,
    localparam int COL_W = $clog2(SCREEN_WIDTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  asp_pkg::cfg_t                cfg,
    input  logic                         q_empty,
    input  logic [asp_pkg::SAMPLE_W-1:0] q_data,
    output logic                         q_pop,
    output asp_pkg::div_req_t            div_req,
    input  logic                         div_busy,
    input  logic [asp_pkg::SAMPLE_W-1:0] div_quot,
    output logic                         empty,
    input  logic                         pop,
    output logic [COL_W-1:0]             column
);

    localparam int SW     = asp_pkg::SAMPLE_W;
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int PROD_W = SW + COL_W;
    localparam int CMP_W  = (asp_pkg::DEPTH_W > CNT_W) ? asp_pkg::DEPTH_W : CNT_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WRITE     = 4'd1;
    localparam logic [3:0] S_SUM       = 4'd2;
    localparam logic [3:0] S_DIV1      = 4'd3;
    localparam logic [3:0] S_DIV1_WAIT = 4'd4;
    localparam logic [3:0] S_MAP       = 4'd5;
    localparam logic [3:0] S_MUL       = 4'd6;
    localparam logic [3:0] S_DIV2      = 4'd7;
    localparam logic [3:0] S_DIV2_WAIT = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [SW-1:0]     window_mem [WINDOW_DEPTH];
    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [SW-1:0]     sample_reg;
    logic [IDX_W-1:0]  wp_reg;
    logic [IDX_W-1:0]  rp_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              rd_vld_reg;
    logic              rd_live_reg;
    logic [SW-1:0]     rd_data_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SW-1:0]     avg_reg;
    logic [SW-1:0]     off_reg;
    logic [SW-1:0]     span_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [COL_W-1:0]  col_reg;
    logic              res_valid_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic              issue;
    logic [CMP_W-1:0]  depth_ext;
    logic [CNT_W-1:0]  count_next;
    logic              res_free;

    assign issue    = (k_reg < count_reg);
    assign res_free = !res_valid_reg || pop;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign empty    = !res_valid_reg;
    assign column   = res_col_reg;

    always_comb
    begin
        depth_ext = CMP_W'(cfg.avg_depth);
        priority if (depth_ext == '0)
        begin
            count_next = CNT_W'(1);
        end
        else if (depth_ext > CMP_W'(WINDOW_DEPTH))
        begin
            count_next = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            count_next = CNT_W'(depth_ext);
        end
    end

    always_comb
    begin
        div_req = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (!issue && !rd_vld_reg)
                begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                div_req.start     = 1'b1;
                div_req.rem_init  = SW'(sum_reg >> SW);
                div_req.quot_init = sum_reg[SW-1:0];
                div_req.divisor   = SW'(count_reg);
                div_req.steps     = asp_pkg::STEP_W'(SW);
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                priority if (avg_reg < cfg.left_bound || avg_reg > cfg.right_bound
                             || cfg.right_bound == cfg.left_bound)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                div_req.start     = 1'b1;
                div_req.rem_init  = SW'(prod_reg >> COL_W);
                div_req.quot_init = SW'(prod_reg[COL_W-1:0]) << (SW - COL_W);
                div_req.divisor   = span_reg;
                div_req.steps     = asp_pkg::STEP_W'(COL_W);
                state_next = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_SUM) && issue;
            if (state_reg == S_WRITE)
            begin
                wp_reg <= (wp_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != CNT_W'(WINDOW_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                k_reg <= '0;
            end
            else if (state_reg == S_SUM && issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == S_OUT && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            window_mem[wp_reg] <= sample_reg;
        end
        rd_data_reg <= window_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sample_reg <= q_data;
                count_reg  <= count_next;
            end
            S_WRITE:
            begin
                rp_reg  <= wp_reg;
                sum_reg <= '0;
            end
            S_SUM:
            begin
                if (issue)
                begin
                    rp_reg      <= (rp_reg == '0) ? IDX_W'(WINDOW_DEPTH - 1) : rp_reg - 1'b1;
                    rd_live_reg <= (k_reg < fill_reg);
                end
                if (rd_vld_reg && rd_live_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                end
            end
            S_DIV1_WAIT:
            begin
                avg_reg <= div_quot;
            end
            S_MAP:
            begin
                off_reg  <= avg_reg - cfg.left_bound;
                span_reg <= cfg.right_bound - cfg.left_bound;
                priority if (avg_reg < cfg.left_bound)
                begin
                    col_reg <= '0;
                end
                else if (avg_reg > cfg.right_bound)
                begin
                    col_reg <= COL_W'(SCREEN_WIDTH);
                end
                else
                begin
                    col_reg <= '0;
                end
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(off_reg) * PROD_W'(SCREEN_WIDTH);
            end
            S_DIV2_WAIT:
            begin
                col_reg <= div_quot[COL_W-1:0];
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    res_col_reg <= col_reg;
                end
            end
            default:
            begin
                sample_reg <= sample_reg;
            end
        endcase
    end

endmodule

// ===== design/averaged_sensor_to_position_top.sv =====
// ----------------------------------------------------------------------------
// averaged_sensor_to_position_top
// Averages the newest sensor samples and maps the average onto a screen
// column between two programmable bounds.
// ----------------------------------------------------------------------------
// The average divides the newest count samples' sum by count, which is avg_depth
// with zero taken as one and capped at the window depth. The one-bit-per-cycle
// divider runs twice per sample, but once when the average lies outside the bounds
// or the bounds are equal. One sample is in the back end at a time, so a new one is
// taken after the last result is registered, paced by the serial read and the divider.
// Reset clears the window fill count and loads the bound and depth registers.
module averaged_sensor_to_position_top
#(
    parameter int WINDOW_DEPTH = asp_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SCREEN_WIDTH = asp_pkg::DEFAULT_SCREEN_WIDTH,
    localparam int COL_W = $clog2(SCREEN_WIDTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [asp_pkg::SAMPLE_W-1:0]  sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [COL_W-1:0]              column,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [asp_pkg::SAMPLE_W-1:0]  cfg_data
);

    asp_pkg::cfg_t                cfg_reg;
    logic                         q_empty;
    logic                         q_pop;
    logic [asp_pkg::SAMPLE_W-1:0] q_data;
    asp_pkg::div_req_t            div_req;
    logic                         div_busy;
    logic [asp_pkg::SAMPLE_W-1:0] div_quot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_bound  <= asp_pkg::LEFT_RESET;
            cfg_reg.right_bound <= asp_pkg::RIGHT_RESET;
            cfg_reg.avg_depth   <= asp_pkg::DEPTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                asp_pkg::CFG_LEFT:  cfg_reg.left_bound  <= cfg_data;
                asp_pkg::CFG_RIGHT: cfg_reg.right_bound <= cfg_data;
                asp_pkg::CFG_DEPTH: cfg_reg.avg_depth   <= cfg_data[asp_pkg::DEPTH_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    asp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_data  (q_data)
    );

    asp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .div_req  (div_req),
        .div_busy (div_busy),
        .div_quot (div_quot)
    );

    asp_back
    #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_busy (div_busy),
        .div_quot (div_quot),
        .empty    (empty),
        .pop      (pop),
        .column   (column)
    );

    // The column never lies beyond the right edge of the screen.
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (column <= COL_W'(SCREEN_WIDTH)))
        else $error("column beyond screen width");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // The back end only takes a request from the queue when one is waiting.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // A started divider is busy in the following cycle.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> div_busy)
        else $error("divider did not start");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for averaged_sensor_to_position_top. A directed
// table covers the bounds, the depth limits, crossed and equal bounds, and a
// window that starts empty. Random phases then vary the registers, the input
// gaps and the output stalls, including one long output hold-off that fills
// the block. Each column is checked against the table where it gives one, else
// against an in-house model of the window average and the linear mapping.
// ----------------------------------------------------------------------------
module tb;
    import asp_pkg::*;

    localparam int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH;
    localparam int SCREEN_WIDTH = DEFAULT_SCREEN_WIDTH;
    localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_WIDTH);
    localparam int PHASES = 9;
    localparam int PRESSURE_PHASE = 4;
    localparam int PHASE_ITEMS = 175;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] depth;
        logic [SAMPLE_W-1:0] value;
        logic                known;
        logic [COL_W-1:0]    column;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [0:24] = '{
        '{LEFT_RESET, RIGHT_RESET, 20'd20, 20'd0,      1'b1, 10'd0},
        '{LEFT_RESET, RIGHT_RESET, 20'd20, SAMPLE_MAX, 1'b0, 10'd0},
        '{LEFT_RESET, RIGHT_RESET, 20'd20, 20'd123456, 1'b0, 10'd0},
        '{20'd1000,   20'd2000,    20'd0,  20'd999,    1'b1, 10'd0},
        '{20'd1000,   20'd2000,    20'd0,  20'd1000,   1'b1, 10'd0},
        '{20'd1000,   20'd2000,    20'd0,  20'd1500,   1'b1, 10'd320},
        '{20'd1000,   20'd2000,    20'd0,  20'd2000,   1'b1, COL_MAX},
        '{20'd1000,   20'd2000,    20'd0,  20'd2001,   1'b1, COL_MAX},
        '{20'd1000,   20'd2000,    20'd0,  SAMPLE_MAX, 1'b1, COL_MAX},
        '{20'd1000,   20'd2000,    20'd0,  20'd0,      1'b1, 10'd0},
        '{20'd5000,   20'd5000,    20'd1,  20'd5000,   1'b1, 10'd0},
        '{20'd5000,   20'd5000,    20'd1,  20'd4999,   1'b1, 10'd0},
        '{20'd5000,   20'd5000,    20'd1,  20'd5001,   1'b1, COL_MAX},
        '{20'd3000,   20'd2000,    20'd1,  20'd2999,   1'b1, 10'd0},
        '{20'd3000,   20'd2000,    20'd1,  20'd3000,   1'b1, COL_MAX},
        '{20'd3000,   20'd2000,    20'd1,  20'd2500,   1'b1, 10'd0},
        '{20'd0,      SAMPLE_MAX,  20'd32, SAMPLE_MAX, 1'b0, 10'd0},
        '{20'd0,      SAMPLE_MAX,  20'd32, SAMPLE_MAX, 1'b0, 10'd0},
        '{20'd0,      SAMPLE_MAX,  20'd32, 20'd0,      1'b0, 10'd0},
        '{20'd0,      SAMPLE_MAX,  20'd63, SAMPLE_MAX, 1'b0, 10'd0},
        '{20'd0,      SAMPLE_MAX,  20'd63, 20'd1,      1'b0, 10'd0},
        '{SAMPLE_MAX, SAMPLE_MAX,  20'hFFFC1, SAMPLE_MAX, 1'b1, 10'd0},
        '{SAMPLE_MAX, SAMPLE_MAX,  20'hFFFC1, 20'hFFFFE,  1'b1, 10'd0},
        '{20'd0,      20'd0,       20'd1,  20'd0,      1'b1, 10'd0},
        '{20'd0,      20'd0,       20'd1,  20'd1,      1'b1, COL_MAX}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [COL_W-1:0]     column;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_data = '0;

    logic [SAMPLE_W-1:0] window_mirror [WINDOW_DEPTH] = '{default: '0};
    logic [SAMPLE_W-1:0] bound_left = LEFT_RESET;
    logic [SAMPLE_W-1:0] bound_right = RIGHT_RESET;
    logic [DEPTH_W-1:0]  depth_setting = DEPTH_RESET;
    logic [SAMPLE_W-1:0] prog_left = LEFT_RESET;
    logic [SAMPLE_W-1:0] prog_right = RIGHT_RESET;
    logic [SAMPLE_W-1:0] prog_depth = SAMPLE_W'(DEPTH_RESET);

    logic [COL_W-1:0] expected_columns [$];
    logic [COL_W-1:0] wanted_column;
    int               mismatches = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    logic             rx_hold = 1'b0;
    int               hold_count = 0;
    int               cycle_count = 0;

    averaged_sensor_to_position_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .column    (column),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [COL_W-1:0] average_to_column(input logic [SAMPLE_W-1:0] value);
        int unsigned       count;
        longint unsigned   total;
        longint unsigned   mean;
        int                k;
        for (k = WINDOW_DEPTH - 1; k > 0; k--)
        begin
            window_mirror[k] = window_mirror[k - 1];
        end
        window_mirror[0] = value;
        count = (depth_setting == '0) ? 1 : int'(depth_setting);
        if (count > WINDOW_DEPTH)
        begin
            count = WINDOW_DEPTH;
        end
        total = 0;
        for (k = 0; k < int'(count); k++)
        begin
            total += longint'(window_mirror[k]);
        end
        mean = total / count;
        if (mean < longint'(bound_left))
        begin
            return '0;
        end
        if (mean > longint'(bound_right))
        begin
            return COL_MAX;
        end
        if (bound_right == bound_left)
        begin
            return '0;
        end
        return COL_W'((mean - longint'(bound_left)) * longint'(SCREEN_WIDTH)
                      / (longint'(bound_right) - longint'(bound_left)));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [SAMPLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (reg_index)
            CFG_LEFT:  bound_left = data;
            CFG_RIGHT: bound_right = data;
            CFG_DEPTH: depth_setting = data[DEPTH_W-1:0];
            default:   ;
        endcase
    endtask

    task automatic program_regs(input logic [SAMPLE_W-1:0] l,
                                input logic [SAMPLE_W-1:0] r,
                                input logic [SAMPLE_W-1:0] d);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_DEPTH, d);
        cfg_valid  <= 1'b0;
        prog_left  = l;
        prog_right = r;
        prog_depth = d;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic known,
                               input logic [COL_W-1:0] known_column);
        int               gap;
        logic [COL_W-1:0] predicted;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predicted = average_to_column(value);
        expected_columns.push_back(known ? known_column : predicted);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_columns.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_columns.size() == 0)
            begin
                mismatches++;
                $display("%0t: column %0d returned with no request outstanding",
                         $time, column);
            end
            else
            begin
                wanted_column = expected_columns.pop_front();
                if (column !== wanted_column)
                begin
                    mismatches++;
                    $display("%0t: column mismatch, expected %0d, got %0d",
                             $time, wanted_column, column);
                end
            end
        end
        if (rx_hold && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            pop <= 1'b0;
        end
        else
        begin
            if (!rx_hold)
            begin
                hold_count <= 0;
            end
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int                  phase;
        int                  item;
        int                  items;
        int                  pick;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         margin;
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        logic [SAMPLE_W-1:0] d;
        logic [SAMPLE_W-1:0] s;
        logic                pressure;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(CFG_UNUSED, SAMPLE_W'($urandom_range(SAMPLE_MAX)));
        cfg_valid <= 1'b0;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].left != prog_left || DIRECTED_ROWS[i].right != prog_right
                || DIRECTED_ROWS[i].depth != prog_depth)
            begin
                drain();
                program_regs(DIRECTED_ROWS[i].left, DIRECTED_ROWS[i].right,
                             DIRECTED_ROWS[i].depth);
            end
            send_sample(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].known,
                        DIRECTED_ROWS[i].column);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            pressure = (phase == PRESSURE_PHASE);
            items = pressure ? PRESSURE_ITEMS : PHASE_ITEMS;
            case (pressure ? 0 : phase % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle_pct = 81;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 81;
                end
                default:
                begin
                    tx_idle_pct = 22;
                    rx_stall_pct <= 22;
                end
            endcase
            rx_hold <= pressure;

            pick = $urandom_range(9);
            if (pick == 0)
            begin
                r = SAMPLE_W'($urandom_range(SAMPLE_MAX - 1));
                l = r + SAMPLE_W'($urandom_range(SAMPLE_MAX - r, 1));
            end
            else if (pick == 1)
            begin
                l = SAMPLE_W'($urandom_range(SAMPLE_MAX));
                r = l;
            end
            else if (pick == 2)
            begin
                l = '0;
                r = SAMPLE_MAX;
            end
            else
            begin
                l = SAMPLE_W'($urandom_range(20'hF0000));
                r = l + SAMPLE_W'($urandom_range(SAMPLE_MAX - l, 1));
            end
            d = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            pick = $urandom_range(3);
            if (pick == 0)
            begin
                d[DEPTH_W-1:0] = DEPTH_W'($urandom_range(4));
            end
            else if (pick == 3)
            begin
                d[DEPTH_W-1:0] = DEPTH_W'($urandom_range(63));
            end
            else
            begin
                d[DEPTH_W-1:0] = DEPTH_W'($urandom_range(32, 1));
            end
            program_regs(l, r, d);

            lo = (l < r) ? l : r;
            hi = (l < r) ? r : l;
            margin = (hi - lo) / 8 + 4;
            lo = (lo > margin) ? lo - margin : 0;
            hi = (hi + margin > SAMPLE_MAX) ? SAMPLE_MAX : hi + margin;

            for (item = 0; item < items; item++)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    s = '0;
                end
                else if (pick < 10)
                begin
                    s = SAMPLE_MAX;
                end
                else if (pick < 30)
                begin
                    s = SAMPLE_W'($urandom_range(SAMPLE_MAX));
                end
                else
                begin
                    s = SAMPLE_W'($urandom_range(hi, lo));
                end
                send_sample(s, 1'b0, '0);
            end
            if (pressure)
            begin
                rx_hold <= 1'b0;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
